@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/gwrs_pkg.sv @@
// ----------------------------------------------------------------------------
// gwrs_pkg
// Types, constants and helper functions for the glyph row styler.
// ----------------------------------------------------------------------------
package gwrs_pkg;

   localparam int unsigned RowW      = 32;
   localparam int unsigned HalfW     = 16;
   localparam int unsigned RidxW     = 4;
   localparam int unsigned WidthW    = 6;
   localparam int unsigned FadeW     = 4;
   localparam int unsigned DitherN   = 64;
   localparam int unsigned DitherIdxW = 6;

   localparam logic [WidthW-1:0] MaxGlyphW  = 6'd32;
   localparam logic [WidthW-1:0] NarrowMaxW = 6'd16;
   localparam logic [WidthW-1:0] ItalicGrow = 6'd7;
   localparam logic [WidthW-1:0] BoldGrow   = 6'd1;
   localparam logic [WidthW-1:0] MaxDrawW   = 6'd40;
   localparam logic [RidxW-1:0]  UlineRow   = 4'd14;
   localparam logic [DitherIdxW-1:0] DitherBase = 6'd60;
   localparam logic [RowW-1:0]   LeftPixel  = 32'h8000_0000;

   typedef logic [RowW-1:0]   row_type;
   typedef logic [HalfW-1:0]  half_type;
   typedef logic [RidxW-1:0]  ridx_type;
   typedef logic [WidthW-1:0] width_type;
   typedef logic [FadeW-1:0]  fade_type;

   typedef struct packed {
      row_type   row_bits;
      ridx_type  row_index;
      width_type glyph_width;
      logic      italic;
      logic      bold;
      logic      underline;
      fade_type  fade_level;
   } req_type;

   typedef struct packed {
      row_type   styled_row;
      logic      wide;
      width_type draw_width;
   } rsp_type;

   // Bayer 4x4 dither masks, four phase words per fade step
   localparam half_type DitherTab [DitherN] = '{
      16'h8888, 16'h0000, 16'h0000, 16'h0000,
      16'h8888, 16'h0000, 16'h2222, 16'h0000,
      16'h8888, 16'h0000, 16'hAAAA, 16'h0000,
      16'hAAAA, 16'h0000, 16'hAAAA, 16'h0000,
      16'hAAAA, 16'h4444, 16'hAAAA, 16'h0000,
      16'hAAAA, 16'h4444, 16'hAAAA, 16'h1111,
      16'hAAAA, 16'h4444, 16'hAAAA, 16'h5555,
      16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
      16'hAAAA, 16'hDDDD, 16'hAAAA, 16'h5555,
      16'hAAAA, 16'hDDDD, 16'hAAAA, 16'h7777,
      16'hAAAA, 16'hDDDD, 16'hAAAA, 16'hFFFF,
      16'hAAAA, 16'hFFFF, 16'hAAAA, 16'hFFFF,
      16'hEEEE, 16'hFFFF, 16'hAAAA, 16'hFFFF,
      16'hEEEE, 16'hFFFF, 16'hBBBB, 16'hFFFF,
      16'hEEEE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF
   };

   // Spread each pixel one to the right, then drop the pixel right after
   // each newly set pixel so that gaps stay open.
   function automatic row_type embolden(input row_type a);
      row_type b;
      row_type n;
      b = a | (a >> 1);
      n = a ^ b;
      return b & ~(n >> 1);
   endfunction

endpackage

@@ rtl/gwrs_style.sv @@
// ----------------------------------------------------------------------------
// gwrs_style
// Combinational styling of one glyph row: italic, bold, underline, fade.
// ----------------------------------------------------------------------------
module gwrs_style (
   input  gwrs_pkg::req_type req,
   output gwrs_pkg::rsp_type rsp
);
   import gwrs_pkg::*;

   width_type            gw_sat;
   width_type            dw_it;
   width_type            dw_bd;
   logic [2:0]           slant;
   row_type              row_it;
   row_type              bd_hi;
   row_type              row_bd;
   row_type              row_ul;
   row_type              row_fd;
   row_type              ul_mask;
   half_type             dmask;
   logic [DitherIdxW-1:0] didx;

   always_comb begin
      gw_sat = (req.glyph_width > MaxGlyphW) ? MaxGlyphW : req.glyph_width;

      // italic: narrow form shifts only the upper half
      slant = 3'd7 - req.row_index[3:1];
      if (req.italic) begin
         if ((gw_sat + ItalicGrow) > NarrowMaxW) begin
            row_it = req.row_bits >> slant;
         end else begin
            row_it = {req.row_bits[31:16] >> slant, req.row_bits[15:0]};
         end
         dw_it = gw_sat + ItalicGrow;
      end else begin
         row_it = req.row_bits;
         dw_it  = gw_sat;
      end

      // bold: narrow form works on the upper half only
      bd_hi = embolden({16'h0000, row_it[31:16]});
      if (req.bold) begin
         if ((dw_it + BoldGrow) > NarrowMaxW) begin
            row_bd = embolden(row_it);
         end else begin
            row_bd = {bd_hi[15:0], row_it[15:0]};
         end
         dw_bd = dw_it + BoldGrow;
      end else begin
         row_bd = row_it;
         dw_bd  = dw_it;
      end

      // underline: top gw_sat pixels, always full width
      ul_mask = $signed(LeftPixel) >>> (gw_sat - 6'd1);
      if (req.underline && (req.row_index == UlineRow) && (gw_sat != '0)) begin
         row_ul = row_bd | ul_mask;
      end else begin
         row_ul = row_bd;
      end

      // fade
      didx  = DitherBase - {req.fade_level, 2'b00} + {4'd0, req.row_index[1:0]};
      dmask = DitherTab[didx];
      if (req.fade_level == '0) begin
         row_fd = row_ul;
      end else if (dw_bd > NarrowMaxW) begin
         row_fd = row_ul & {dmask, dmask};
      end else begin
         row_fd = row_ul & {dmask, 16'hFFFF};
      end

      rsp.styled_row = row_fd;
      rsp.wide       = (dw_bd > NarrowMaxW);
      rsp.draw_width = dw_bd;
   end

endmodule

@@ rtl/glyph_row_styler_top.sv @@
// ----------------------------------------------------------------------------
// glyph_row_styler_top
// Glyph row styler: one 32-bit bitmap row in, one styled row out.
// ----------------------------------------------------------------------------
//
//  channel  | ports             | handshake
//  ---------+-------------------+-----------------------------------------
//  request  | start, busy, req_ | word taken when start=1 and busy=0
//  response | rsp_valid, rsp_   | one-cycle strobe, receiver always takes
//
//  Path: input register, styling logic, result register.
//  One row per cycle sustained; busy is never raised.
//  The styling path (shift, embolden, mask) sits between the two registers.
//  Reset (synchronous, active high) clears only the valid flags.
//  The receiver cannot stall, so no skid storage is needed.
//
module glyph_row_styler_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  gwrs_pkg::row_type          req_row_bits,
   input  gwrs_pkg::ridx_type         req_row_index,
   input  gwrs_pkg::width_type        req_glyph_width,
   input  logic                       req_italic,
   input  logic                       req_bold,
   input  logic                       req_underline,
   input  gwrs_pkg::fade_type         req_fade_level,
   output logic                       rsp_valid,
   output gwrs_pkg::row_type          rsp_styled_row,
   output logic                       rsp_wide,
   output gwrs_pkg::width_type        rsp_draw_width
);
   import gwrs_pkg::*;
`include "assert_macros.svh"

   // input stage
   logic    in_vld_ff;
   logic    in_vld_in;
   req_type in_word_ff;
   req_type in_word_in;

   // result stage
   logic    out_vld_ff;
   logic    out_vld_in;
   rsp_type out_word_ff;
   rsp_type out_word_in;

   assign busy = 1'b0;

   always_comb begin
      in_vld_in              = start & ~busy;
      in_word_in.row_bits    = req_row_bits;
      in_word_in.row_index   = req_row_index;
      in_word_in.glyph_width = req_glyph_width;
      in_word_in.italic      = req_italic;
      in_word_in.bold        = req_bold;
      in_word_in.underline   = req_underline;
      in_word_in.fade_level  = req_fade_level;
      out_vld_in             = in_vld_ff;
   end

   gwrs_style u_style (
      .req (in_word_ff),
      .rsp (out_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_styled_row = out_word_ff.styled_row;
   assign rsp_wide       = out_word_ff.wide;
   assign rsp_draw_width = out_word_ff.draw_width;

   // every accepted word passes through the input register to rsp_valid, and no result appears without one
   `ASSERT_NEXT(a_accept_to_stage, clock, reset, start && !busy, in_vld_ff)
   `ASSERT_NEXT(a_stage_to_rsp, clock, reset, in_vld_ff, rsp_valid)
   `ASSERT_NEXT(a_no_phantom, clock, reset, !in_vld_ff, !rsp_valid)
   // wide flag agrees with the reported width, which stays in range
   `ASSERT_IMPLIES(a_wide_match, clock, reset, rsp_valid,
      (rsp_wide == (rsp_draw_width > NarrowMaxW)) && (rsp_draw_width <= MaxDrawW))

endmodule

@@ verif/glyph_row_styler_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_row_styler_top_tb
// Self-checking bench for the glyph row styler.
// Sends bitmap rows through the start/busy command port: a directed set
// first, then random rows in bursts. A local model predicts each styled
// row, and every rsp_valid strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module glyph_row_styler_top_tb;
   import gwrs_pkg::*;

   localparam int unsigned RandomRows = 1330;
   // Cycles with no word moving on either side before the run is called hung
   localparam int unsigned IdleLimit  = 1000;
   // Extra cycles after the last result; the block has two register stages
   localparam int unsigned DrainWait  = 6;
   localparam int unsigned ReportMax  = 10;

   // Ordered Bayer fade masks: four row phases per fade step
   localparam half_type FadeMasks [64] = '{
      16'h8888, 16'h0000, 16'h0000, 16'h0000,
      16'h8888, 16'h0000, 16'h2222, 16'h0000,
      16'h8888, 16'h0000, 16'hAAAA, 16'h0000,
      16'hAAAA, 16'h0000, 16'hAAAA, 16'h0000,
      16'hAAAA, 16'h4444, 16'hAAAA, 16'h0000,
      16'hAAAA, 16'h4444, 16'hAAAA, 16'h1111,
      16'hAAAA, 16'h4444, 16'hAAAA, 16'h5555,
      16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
      16'hAAAA, 16'hDDDD, 16'hAAAA, 16'h5555,
      16'hAAAA, 16'hDDDD, 16'hAAAA, 16'h7777,
      16'hAAAA, 16'hDDDD, 16'hAAAA, 16'hFFFF,
      16'hAAAA, 16'hFFFF, 16'hAAAA, 16'hFFFF,
      16'hEEEE, 16'hFFFF, 16'hAAAA, 16'hFFFF,
      16'hEEEE, 16'hFFFF, 16'hBBBB, 16'hFFFF,
      16'hEEEE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF
   };

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   row_type   req_row_bits;
   ridx_type  req_row_index;
   width_type req_glyph_width;
   logic      req_italic;
   logic      req_bold;
   logic      req_underline;
   fade_type  req_fade_level;
   logic      rsp_valid;
   row_type   rsp_styled_row;
   logic      rsp_wide;
   width_type rsp_draw_width;

   rsp_type     styled_rows_due[$];
   int unsigned error_count;
   int unsigned idle_cycles;

   glyph_row_styler_top u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_row_bits    (req_row_bits),
      .req_row_index   (req_row_index),
      .req_glyph_width (req_glyph_width),
      .req_italic      (req_italic),
      .req_bold        (req_bold),
      .req_underline   (req_underline),
      .req_fade_level  (req_fade_level),
      .rsp_valid       (rsp_valid),
      .rsp_styled_row  (rsp_styled_row),
      .rsp_wide        (rsp_wide),
      .rsp_draw_width  (rsp_draw_width)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // --------------------------------------------------------------------
   // Prediction
   // --------------------------------------------------------------------

   // Bold stroke: smear one pixel right, then clear the pixel just past
   // each freshly set one so single-pixel gaps survive.
   function automatic row_type thicken_pixels(input row_type a);
      row_type smeared;
      smeared = a | (a >> 1);
      return smeared & ~((a ^ smeared) >> 1);
   endfunction

   function automatic rsp_type style_glyph_row(input req_type r);
      rsp_type   res;
      row_type   row;
      row_type   upper;
      width_type gw;
      width_type dw;
      logic [2:0] slant;
      logic [5:0] mask_idx;
      half_type  mask;
      row = r.row_bits;
      // widths past one cell saturate before anything else sees them
      gw = (r.glyph_width > MaxGlyphW) ? MaxGlyphW : r.glyph_width;
      dw = gw;
      if (r.italic) begin
         slant = 3'd7 - r.row_index[3:1];
         if (dw + ItalicGrow > NarrowMaxW) begin
            row = row >> slant;
         end else begin
            row = {row[31:16] >> slant, row[15:0]};
         end
         dw = dw + ItalicGrow;
      end
      if (r.bold) begin
         if (dw + BoldGrow > NarrowMaxW) begin
            row = thicken_pixels(row);
         end else begin
            upper = thicken_pixels({16'h0000, row[31:16]});
            row = {upper[15:0], row[15:0]};
         end
         dw = dw + BoldGrow;
      end
      // underline covers the top gw pixels in wide and narrow form alike, zero width draws nothing
      if (r.underline && r.row_index == UlineRow && gw != '0) begin
         row = row | ({RowW{1'b1}} << (RowW - gw));
      end
      if (r.fade_level != '0) begin
         mask_idx = DitherBase - {r.fade_level, 2'b00} + r.row_index[1:0];
         mask = FadeMasks[mask_idx];
         if (dw > NarrowMaxW) begin
            row = row & {mask, mask};
         end else begin
            row = row & {mask, 16'hFFFF};
         end
      end
      res.styled_row = row;
      res.wide       = (dw > NarrowMaxW);
      res.draw_width = dw;
      return res;
   endfunction

   // --------------------------------------------------------------------
   // Sending side
   // --------------------------------------------------------------------

   // Present one row and hold it until the block takes it. The prediction
   // is queued as the word is driven, so it is always in place before the
   // matching strobe can show up.
   task automatic send_row(input req_type r);
      start           <= 1'b1;
      req_row_bits    <= r.row_bits;
      req_row_index   <= r.row_index;
      req_glyph_width <= r.glyph_width;
      req_italic      <= r.italic;
      req_bold        <= r.bold;
      req_underline   <= r.underline;
      req_fade_level  <= r.fade_level;
      styled_rows_due.push_back(style_glyph_row(r));
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_gap(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic req_type make_row(input row_type bits, input int unsigned ridx,
                                        input int unsigned gw, input logic it,
                                        input logic bd, input logic ul,
                                        input int unsigned fade);
      req_type r;
      r.row_bits    = bits;
      r.row_index   = ridx_type'(ridx);
      r.glyph_width = width_type'(gw);
      r.italic      = it;
      r.bold        = bd;
      r.underline   = ul;
      r.fade_level  = fade_type'(fade);
      return r;
   endfunction

   // --------------------------------------------------------------------
   // Result checking: the receiver always takes, so every strobe counts
   // --------------------------------------------------------------------

   task automatic note_error(input string msg);
      if (error_count < ReportMax) $display("%0t ERROR %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_valid) begin
         if (styled_rows_due.size() == 0) begin
            note_error($sformatf("unexpected word row=%h wide=%b dw=%0d",
                                 rsp_styled_row, rsp_wide, rsp_draw_width));
         end else begin
            due = styled_rows_due.pop_front();
            if (rsp_styled_row !== due.styled_row || rsp_wide !== due.wide ||
                rsp_draw_width !== due.draw_width) begin
               note_error($sformatf("exp row=%h wide=%b dw=%0d got row=%h wide=%b dw=%0d",
                                    due.styled_row, due.wide, due.draw_width,
                                    rsp_styled_row, rsp_wide, rsp_draw_width));
            end
         end
      end
   end

   // Watchdog: any word moving on either port resets the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("glyph_row_styler_top_tb: done, errors");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------

   // Corners of every field, all styles off and all on
   task automatic test_field_extremes();
      send_row(make_row(32'h0000_0000, 0, 0, 1'b0, 1'b0, 1'b0, 0));
      send_row(make_row(32'hFFFF_FFFF, 15, 32, 1'b1, 1'b1, 1'b1, 15));
      send_row(make_row(32'h8000_0001, 0, 32, 1'b1, 1'b0, 1'b0, 0));
      send_row(make_row(32'hA5A5_5A5A, 15, 1, 1'b0, 1'b1, 1'b0, 15));
      idle_gap(3);
      send_row(make_row(32'h5555_5555, 7, 20, 1'b0, 1'b1, 1'b0, 0));
   endtask

   // Widths 33..63 clamp to 32, so the draw width tops out at 40
   task automatic test_width_saturation();
      send_row(make_row(32'hF0F0_0F0F, 14, 33, 1'b1, 1'b1, 1'b1, 0));
      send_row(make_row(32'h1234_5678, 14, 48, 1'b0, 1'b0, 1'b1, 3));
      send_row(make_row(32'hCAFE_F00D, 2, 63, 1'b1, 1'b1, 1'b0, 9));
   endtask

   // Underline lands only on row 14; zero width draws nothing
   task automatic test_underline_row();
      send_row(make_row(32'h0000_0000, 14, 0, 1'b0, 1'b0, 1'b1, 0));
      send_row(make_row(32'h0000_0000, 14, 1, 1'b0, 1'b0, 1'b1, 0));
      send_row(make_row(32'h0000_0001, 14, 16, 1'b0, 1'b0, 1'b1, 0));
      send_row(make_row(32'h0000_0000, 14, 31, 1'b1, 1'b0, 1'b1, 0));
      send_row(make_row(32'h0000_0000, 14, 32, 1'b0, 1'b0, 1'b1, 0));
      send_row(make_row(32'h0000_0000, 13, 32, 1'b0, 1'b0, 1'b1, 0));
   endtask

   // Mask words, wide and narrow, across the row phases
   task automatic test_fade_masks();
      send_row(make_row(32'hFFFF_FFFF, 0, 8, 1'b0, 1'b0, 1'b0, 1));
      send_row(make_row(32'hFFFF_FFFF, 1, 24, 1'b0, 1'b0, 1'b0, 8));
      idle_gap(1);
      send_row(make_row(32'hFFFF_FFFF, 2, 4, 1'b0, 1'b0, 1'b0, 14));
      send_row(make_row(32'hFFFF_FFFF, 3, 30, 1'b0, 1'b0, 1'b0, 15));
   endtask

   // Wide/narrow switch points: italic past width 9, bold past width 15
   task automatic test_width_thresholds();
      send_row(make_row(32'hFF00_FF00, 0, 9, 1'b1, 1'b0, 1'b0, 0));
      send_row(make_row(32'hFF00_FF00, 0, 10, 1'b1, 1'b0, 1'b0, 0));
      send_row(make_row(32'h9249_2492, 5, 15, 1'b0, 1'b1, 1'b0, 0));
      send_row(make_row(32'h9249_2492, 5, 16, 1'b0, 1'b1, 1'b0, 0));
   endtask

   // Random rows in bursts; some bursts run back to back without a gap
   task automatic test_random_rows();
      int unsigned sent;
      int unsigned burst;
      int unsigned k;
      req_type     r;
      sent = 0;
      while (sent < RandomRows) begin
         burst = $urandom_range(1, 48);
         for (k = 0; k < burst; k++) begin
            case ($urandom_range(0, 3))
               0: r.row_bits = $urandom;
               1: r.row_bits = {16'($urandom), 16'h0000};   // narrow glyph
               2: r.row_bits = (32'h1 << $urandom_range(0, 31)) |
                               (32'h1 << $urandom_range(0, 31));
               default: r.row_bits = $urandom & $urandom;
            endcase
            // row 14 comes up often so underline gets real exercise
            r.row_index = ($urandom_range(0, 3) == 0) ? UlineRow : ridx_type'($urandom);
            // mostly legal widths, now and then one past the cell
            r.glyph_width = ($urandom_range(0, 7) == 0) ? width_type'($urandom_range(33, 63))
                                                        : width_type'($urandom_range(0, 32));
            r.italic      = 1'($urandom_range(0, 1));
            r.bold        = 1'($urandom_range(0, 1));
            r.underline   = 1'($urandom_range(0, 1));
            r.fade_level  = ($urandom_range(0, 3) == 0) ? fade_type'(0) : fade_type'($urandom);
            send_row(r);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
      end
   endtask

   // --------------------------------------------------------------------
   // Sequence
   // --------------------------------------------------------------------
   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_row_bits    <= '0;
      req_row_index   <= '0;
      req_glyph_width <= '0;
      req_italic      <= 1'b0;
      req_bold        <= 1'b0;
      req_underline   <= 1'b0;
      req_fade_level  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_width_saturation();
      test_underline_row();
      test_fade_masks();
      test_width_thresholds();
      test_random_rows();

      // drain: the watchdog covers a result that never shows
      start <= 1'b0;
      while (styled_rows_due.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      if (error_count == 0 && styled_rows_due.size() == 0) begin
         $display("glyph_row_styler_top_tb: done, clean");
      end else begin
         $display("glyph_row_styler_top_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/gwrs_pkg.sv
rtl/gwrs_style.sv
rtl/glyph_row_styler_top.sv
verif/glyph_row_styler_top_tb.sv
